// File: rtl/core/hdru_pkg.sv
// hdru_pkg: shared constants and types for the dense hll register update unit
// no dependencies
package hdru_pkg;

  // murmurhash64a constants
  localparam logic [63:0] MUR_M     = 64'hc6a4a7935bd1e995;
  localparam int          MUR_R     = 47;
  localparam logic [63:0] HASH_SEED = 64'h00000000adc83b19;

  // default store geometry
  localparam int DEF_INDEX_BITS    = 14;
  localparam int DEF_REGISTER_BITS = 6;

  // fixed payload widths
  localparam int WORD_W   = 64;
  localparam int LEN_W    = 16;
  localparam int IDX_W    = 14;
  localparam int VAL_W    = 6;

  // command codes
  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_MERGE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

endpackage

// File: rtl/core/hdru_req_if.sv
// hdru_req_if: request channel carrying key chunks and register commands
// depends on hdru_pkg
interface hdru_req_if;
  import hdru_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [WORD_W-1:0]   key_word;
  logic [LEN_W-1:0]    key_length;
  logic                last_chunk;
  logic [IDX_W-1:0]    reg_index;
  logic [VAL_W-1:0]    reg_value;

  modport source (output valid, command, key_word, key_length, last_chunk, reg_index,
                  reg_value, input ready);
  modport sink (input valid, command, key_word, key_length, last_chunk, reg_index,
                reg_value, output ready);
endinterface

// File: rtl/core/hdru_rsp_if.sv
// hdru_rsp_if: result channel carrying register update outcomes
// depends on hdru_pkg
interface hdru_rsp_if;
  import hdru_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  result_index;
  logic [VAL_W-1:0]  result_value;
  logic [VAL_W-1:0]  old_value;
  logic              changed;

  modport source (output valid, result_index, result_value, old_value, changed,
                  input ready);
  modport sink (input valid, result_index, result_value, old_value, changed,
                output ready);
endinterface

// File: rtl/core/hll_dense_register_update_unit.sv
// hll_dense_register_update_unit: murmurhash64a key hashing and dense hll register store
// depends on hdru_pkg, hdru_req_if, hdru_rsp_if
// sequencing: a merge or read goes through S_RD and S_MOD before its result is registered;
//   a key chunk runs S_M_K1, S_M_K2 and S_M_H for a full block or S_M_H for a tail, after
//   S_M_LEN on a key's first chunk (an empty key skips the block); a last chunk then adds
//   final mix, rank search and update. One transfer at a time; each 64-bit multiply is
//   built from three partial products on one 32x32 unit; the next transfer is taken in idle
// reset: clears control state, then sweeps all 2**INDEX_BITS entries (16384 by default) of
//   the register store to zero, one entry per cycle, before the first transfer is taken
module hll_dense_register_update_unit #(
  parameter int INDEX_BITS    = hdru_pkg::DEF_INDEX_BITS,
  parameter int REGISTER_BITS = hdru_pkg::DEF_REGISTER_BITS
) (
  input  logic        clk,
  input  logic        rst,
  hdru_req_if.sink    req,
  hdru_rsp_if.source  rsp
);
  import hdru_pkg::*;

  localparam int RANK_BITS = 64 - INDEX_BITS;
  localparam int DEPTH     = 1 << INDEX_BITS;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_M_LEN = 11'b000_0000_0100,
    S_DISP  = 11'b000_0000_1000,
    S_M_K1  = 11'b000_0001_0000,
    S_M_K2  = 11'b000_0010_0000,
    S_M_H   = 11'b000_0100_0000,
    S_M_F   = 11'b000_1000_0000,
    S_RANK  = 11'b001_0000_0000,
    S_RD    = 11'b010_0000_0000,
    S_MOD   = 11'b100_0000_0000
  } state_t;

  state_t state;

  // register store
  logic [REGISTER_BITS-1:0] mem [DEPTH];
  logic [REGISTER_BITS-1:0] rdata;
  logic                     mem_we;
  logic [INDEX_BITS-1:0]    mem_waddr;
  logic [REGISTER_BITS-1:0] mem_wdata;
  logic [INDEX_BITS-1:0]    clr_addr;

  // key and command context
  logic [63:0]           word_r;
  logic                  last_r;
  logic                  skip_r;
  logic [2:0]            tail;
  logic                  in_key;
  logic [63:0]           hacc;
  logic [63:0]           hreg;
  logic [INDEX_BITS-1:0] ridx;
  logic [VAL_W-1:0]      cand;
  logic                  is_read;
  logic [VAL_W-1:0]      rank;
  logic [63:0]           rest;

  // shared multiply unit
  logic [63:0] mop;
  logic [63:0] macc;
  logic [1:0]  mcnt;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] mres;
  logic        mdone;
  logic        in_mul;

  // output register
  logic                out_valid;
  logic [IDX_W-1:0]    out_index;
  logic [VAL_W-1:0]    out_new;
  logic [VAL_W-1:0]    out_old;
  logic                out_chg;
  logic                out_free;

  logic [15:0]              idx_wide;
  logic [15:0]              ridx_wide;
  logic [REGISTER_BITS-1:0] cand_ext;
  logic                     raise;
  logic [63:0]              tail_mask;
  logic [63:0]              fin_h;
  logic [63:0]              kmix;
  logic [63:0]              fmix;

  function automatic logic [2:0] ctz8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) n = 3'(i);
    end
    return n;
  endfunction

  // multiply by the hash constant, low 64 bits, one partial product per cycle
  assign in_mul = (state == S_M_LEN) || (state == S_M_K1) || (state == S_M_K2) ||
                  (state == S_M_H) || (state == S_M_F);
  always_comb begin
    case (mcnt)
      2'd0:    begin mul_a = mop[31:0];  mul_b = MUR_M[31:0];  end
      2'd1:    begin mul_a = mop[31:0];  mul_b = MUR_M[63:32]; end
      default: begin mul_a = mop[63:32]; mul_b = MUR_M[31:0];  end
    endcase
  end
  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign mres  = macc + {prod[31:0], 32'd0};
  assign mdone = in_mul && (mcnt == 2'd2);

  // derived datapath values
  assign idx_wide  = 16'(req.reg_index);
  assign ridx_wide = 16'(ridx);
  assign cand_ext  = REGISTER_BITS'(cand);
  assign raise     = !is_read && (cand_ext > rdata);
  assign tail_mask = (64'd1 << {tail, 3'b000}) - 64'd1;
  assign fin_h     = (state == S_DISP) ? hacc : mres;
  assign kmix      = mres ^ (mres >> MUR_R);
  assign fmix      = mres ^ (mres >> MUR_R);
  assign out_free  = !out_valid || rsp.ready;

  // store write port: clearing sweep or read-modify-write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ridx;
    mem_wdata = cand_ext;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_MOD && out_free && raise) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[ridx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      in_key    <= 1'b0;
      tail      <= 3'd0;
      hacc      <= '0;
      mcnt      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (in_mul) begin
        if (mcnt == 2'd0) macc <= prod;
        else              macc <= mres;
        mcnt <= (mcnt == 2'd2) ? 2'd0 : mcnt + 2'd1;
      end

      // result taken; a new one loaded in S_MOD overrides this
      if (out_valid && rsp.ready && state != S_MOD) out_valid <= 1'b0;

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            word_r <= req.key_word;
            last_r <= req.last_chunk;
            ridx   <= idx_wide[INDEX_BITS-1:0];
            cand   <= req.reg_value;
            case (req.command)
              CMD_KEY: begin
                if (!in_key) begin
                  mop    <= 64'(req.key_length);
                  tail   <= req.key_length[2:0];
                  skip_r <= (req.key_length == '0);
                  state  <= S_M_LEN;
                end else begin
                  skip_r <= 1'b0;
                  state  <= S_DISP;
                end
              end
              CMD_MERGE: begin
                is_read <= 1'b0;
                state   <= S_RD;
              end
              CMD_READ: begin
                is_read <= 1'b1;
                state   <= S_RD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_M_LEN: begin
          if (mdone) begin
            hacc  <= HASH_SEED ^ mres;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          if (skip_r) begin
            if (!last_r) begin
              hacc   <= fin_h;
              in_key <= 1'b1;
              state  <= S_IDLE;
            end else begin
              hacc   <= '0;
              in_key <= 1'b0;
              tail   <= 3'd0;
              mop    <= fin_h ^ (fin_h >> MUR_R);
              state  <= S_M_F;
            end
          end else if (last_r && tail != 3'd0) begin
            mop   <= hacc ^ (word_r & tail_mask);
            state <= S_M_H;
          end else begin
            mop   <= word_r;
            hreg  <= hacc;
            state <= S_M_K1;
          end
        end
        S_M_K1: begin
          if (mdone) begin
            mop   <= kmix;
            state <= S_M_K2;
          end
        end
        S_M_K2: begin
          if (mdone) begin
            mop   <= hreg ^ mres;
            state <= S_M_H;
          end
        end
        S_M_H: begin
          if (mdone) begin
            if (!last_r) begin
              hacc   <= fin_h;
              in_key <= 1'b1;
              state  <= S_IDLE;
            end else begin
              hacc   <= '0;
              in_key <= 1'b0;
              tail   <= 3'd0;
              mop    <= fin_h ^ (fin_h >> MUR_R);
              state  <= S_M_F;
            end
          end
        end
        S_M_F: begin
          if (mdone) begin
            ridx    <= fmix[INDEX_BITS-1:0];
            rest    <= (fmix >> INDEX_BITS) | (64'd1 << RANK_BITS);
            rank    <= VAL_W'(1);
            is_read <= 1'b0;
            state   <= S_RANK;
          end
        end
        // trailing zero search, one byte per cycle
        S_RANK: begin
          if (rest[7:0] != 8'd0) begin
            cand  <= rank + VAL_W'(ctz8(rest[7:0]));
            state <= S_RD;
          end else begin
            rank <= rank + VAL_W'(8);
            rest <= rest >> 8;
          end
        end
        S_RD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_index <= ridx_wide[IDX_W-1:0];
            out_old   <= rdata[VAL_W-1:0];
            out_new   <= raise ? cand : rdata[VAL_W-1:0];
            out_chg   <= raise;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.result_index = out_index;
  assign rsp.result_value = out_new;
  assign rsp.old_value    = out_old;
  assign rsp.changed      = out_chg;

endmodule
